// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is low
`define PTRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptrs assertion failed");

// next-cycle implication, quiet while reset is low
`define PTRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptrs assertion failed");

`endif

// ===== rtl/ptrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared widths, state codes and controller/datapath bundles for the
// prime range scan core.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  localparam int RANGE_W = 16;
  localparam int COUNT_W = 17;
  localparam int TWIN_W  = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_INIT,
    ST_CHECK,
    ST_DIV,
    ST_VERDICT,
    ST_NEXT,
    ST_FINISH
  } state_t;

  // which operand the primality test works on
  typedef enum logic [1:0] {
    PH_CUR,
    PH_MINUS,
    PH_PLUS
  } phase_t;

  typedef struct packed {
    logic   load_item;
    logic   tinit;
    phase_t sel;
    logic   start_rem;
    logic   step_d;
    logic   count_inc;
    logic   twin_set;
    logic   v_inc;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic lo_gt_hi;
    logic n_lt2;
    logic sq_gt_n;
    logic rem_done;
    logic rem_zero;
    logic rem_busy;
    logic v_ge2;
    logic v_eq_hi;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/ptrs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_in_if
// Range request channel: valid/ready plus the inclusive scan bounds.
// ----------------------------------------------------------------------------
interface ptrs_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptrs_pkg::RANGE_W-1:0]  range_low;
  logic [ptrs_pkg::RANGE_W-1:0]  range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

// ===== rtl/ptrs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_out_if
// Result channel: valid/ready plus prime count and largest twin prime.
// ----------------------------------------------------------------------------
interface ptrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptrs_pkg::COUNT_W-1:0]  prime_count;
  logic [ptrs_pkg::TWIN_W-1:0]   largest_twin;

  modport source (output valid, output prime_count, output largest_twin, input ready);
  modport sink   (input valid, input prime_count, input largest_twin, output ready);
endinterface

// ===== rtl/ptrs_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptrs_rem_unit #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] rem
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] dsr_r;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {rem_r, q_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == CW'(WIDTH - 1)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits WIDTH bits
      if (!diff[WIDTH]) begin
        rem_r <= diff[WIDTH-1:0];
      end else begin
        rem_r <= shifted[WIDTH-1:0];
      end
      q_r   <= {q_r[WIDTH-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/ptrs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_datapath
// Scan value, trial divisor and square, tallies and the result register.
// ----------------------------------------------------------------------------
module ptrs_datapath #(
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ptrs_pkg::RANGE_W-1:0]  in_range_low,
  input  logic [ptrs_pkg::RANGE_W-1:0]  in_range_high,
  input  ptrs_pkg::dp_cmd_t             cmd,
  output ptrs_pkg::dp_sts_t             sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [ptrs_pkg::COUNT_W-1:0]  out_prime_count,
  output logic [ptrs_pkg::TWIN_W-1:0]   out_largest_twin
);
  import ptrs_pkg::*;

  // one spare bit so value+2 and the end of the scan never wrap
  localparam int VW = VALUE_BITS + 1;
  localparam int SW = VW + 1;
  localparam logic [VW-1:0] VMASK = {1'b0, {VALUE_BITS{1'b1}}};

  logic [VW-1:0]      v_r;
  logic [VW-1:0]      hi_r;
  logic [VW-1:0]      n_r;
  logic [VW-1:0]      d_r;
  logic [SW-1:0]      sq_r;
  logic [COUNT_W-1:0] count_r;
  logic [TWIN_W-1:0]  twin_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic [TWIN_W-1:0]  out_twin_r;
  logic [VW-1:0]      n_sel;
  logic               rem_busy;
  logic               rem_done;
  logic [VW-1:0]      rem_val;

  always_comb begin
    unique case (cmd.sel)
      PH_CUR:   n_sel = v_r;
      PH_MINUS: n_sel = v_r - VW'(2);
      PH_PLUS:  n_sel = v_r + VW'(2);
      default:  n_sel = v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      v_r     <= VW'(in_range_low) & VMASK;
      hi_r    <= VW'(in_range_high) & VMASK;
      count_r <= '0;
      twin_r  <= '0;
    end else begin
      if (cmd.v_inc) begin
        v_r <= v_r + VW'(1);
      end
      if (cmd.count_inc) begin
        count_r <= count_r + COUNT_W'(1);
      end
      if (cmd.twin_set) begin
        twin_r <= TWIN_W'(v_r);
      end
    end
    if (cmd.tinit) begin
      n_r  <= n_sel;
      d_r  <= VW'(2);
      sq_r <= SW'(4);
    end else if (cmd.step_d) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_r  <= d_r + VW'(1);
      sq_r <= sq_r + {d_r, 1'b1};
    end
    if (cmd.out_load) begin
      out_count_r <= count_r;
      out_twin_r  <= twin_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  ptrs_rem_unit #(
    .WIDTH (VW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_rem),
    .dividend (n_r),
    .divisor  (d_r),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign sts.lo_gt_hi = v_r > hi_r;
  assign sts.n_lt2    = n_r < VW'(2);
  assign sts.sq_gt_n  = sq_r > {1'b0, n_r};
  assign sts.rem_done = rem_done;
  assign sts.rem_zero = rem_val == '0;
  assign sts.rem_busy = rem_busy;
  assign sts.v_ge2    = v_r >= VW'(2);
  assign sts.v_eq_hi  = v_r == hi_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_prime_count  = out_count_r;
  assign out_largest_twin = out_twin_r;

endmodule

// ===== rtl/ptrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_ctrl
// Sequencer: walks the range, tests value and, for a prime value, tests value-2 and, if not prime, value+2.
// ----------------------------------------------------------------------------
module ptrs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptrs_pkg::dp_sts_t sts,
  output ptrs_pkg::dp_cmd_t cmd
);
  import ptrs_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   prime_r, prime_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_CUR;
      prime_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      prime_r <= prime_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    prime_nxt = prime_r;
    cmd       = '0;
    cmd.sel   = phase_r;
    in_ready  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          phase_nxt     = PH_CUR;
          state_nxt     = ST_RANGE;
        end
      end
      ST_RANGE: begin
        state_nxt = sts.lo_gt_hi ? ST_FINISH : ST_INIT;
      end
      ST_INIT: begin
        cmd.tinit = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts.n_lt2) begin
          prime_nxt = 1'b0;
          state_nxt = ST_VERDICT;
        end else if (sts.sq_gt_n) begin
          // no divisor up to the square root
          prime_nxt = 1'b1;
          state_nxt = ST_VERDICT;
        end else begin
          cmd.start_rem = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            prime_nxt = 1'b0;
            state_nxt = ST_VERDICT;
          end else begin
            cmd.step_d = 1'b1;
            state_nxt  = ST_CHECK;
          end
        end
      end
      ST_VERDICT: begin
        unique case (phase_r)
          PH_CUR: begin
            if (prime_r) begin
              cmd.count_inc = 1'b1;
              phase_nxt     = sts.v_ge2 ? PH_MINUS : PH_PLUS;
              state_nxt     = ST_INIT;
            end else begin
              state_nxt = ST_NEXT;
            end
          end
          PH_MINUS: begin
            if (prime_r) begin
              cmd.twin_set = 1'b1;
              state_nxt    = ST_NEXT;
            end else begin
              phase_nxt = PH_PLUS;
              state_nxt = ST_INIT;
            end
          end
          PH_PLUS: begin
            cmd.twin_set = prime_r;
            state_nxt    = ST_NEXT;
          end
          default: begin
            state_nxt = ST_NEXT;
          end
        endcase
      end
      ST_NEXT: begin
        phase_nxt = PH_CUR;
        if (sts.v_eq_hi) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.v_inc = 1'b1;
          state_nxt = ST_INIT;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/prime_twin_range_scan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_twin_range_scan_core
// Counts primes in an inclusive range by trial division and reports the
// largest twin prime in it.
// ----------------------------------------------------------------------------
//  channel | dir | beat payload
//  in_ch   | in  | range_low[15:0], range_high[15:0]
//  out_ch  | out | prime_count[16:0], largest_twin[15:0]
//
//  one range beat at a time; the next is taken once the result is staged,
//  while that result may still wait on out_ch.ready
//  each trial divisor runs the serial remainder unit plus a check; a prime
//  test of n needs up to floor(sqrt(n))-1 trials, and a value v needs up to
//  three tests (v, v-2, v+2)
//  synchronous active-low reset returns the sequencer to idle; a held result
//  stays put while out_ch.ready is low
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prime_twin_range_scan_core #(
  parameter int VALUE_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  ptrs_in_if.sink    in_ch,
  ptrs_out_if.source out_ch
);
  import ptrs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  ptrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptrs_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_range_low     (in_ch.range_low),
    .in_range_high    (in_ch.range_high),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_prime_count  (out_ch.prime_count),
    .out_largest_twin (out_ch.largest_twin)
  );

  assign in_ch.ready = in_ready;

  // a taken range keeps the core busy for at least the next cycle
  `PTRS_ASSERT_NXT(a_busy_after_beat, clk, rst_n, in_ch.valid && in_ready, !in_ready)
  // divider is never restarted mid-run
  `PTRS_ASSERT_IMP(a_rem_no_restart, clk, rst_n, cmd.start_rem, !sts.rem_busy)
  // no divide left running when a new range may come in
  `PTRS_ASSERT_IMP(a_idle_rem_quiet, clk, rst_n, in_ready, !sts.rem_busy)

endmodule
